>>> rtl/core/jkse_pkg.sv
// Shared types and constants for the JSON keyed string extractor.
// Standalone package; used by jkse_cfg_regs and json_keyed_string_extractor.
`default_nettype none

package jkse_pkg;

  localparam int unsigned MaxKey   = 48;
  localparam int unsigned KeyWords = 6;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned DataW    = 64;

  localparam logic [15:0] CapacityReset = 16'd256;

  localparam logic KindByte  = 1'b0;
  localparam logic KindFinal = 1'b1;

  typedef enum logic [2:0] {
    REG_KEY_LENGTH   = 3'd0,
    REG_OUT_CAPACITY = 3'd1,
    REG_KEY_A        = 3'd2,
    REG_KEY_B        = 3'd3,
    REG_KEY_C        = 3'd4,
    REG_KEY_D        = 3'd5,
    REG_KEY_E        = 3'd6,
    REG_KEY_F        = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    OC_NOT_FOUND = 2'd0,
    OC_OK        = 2'd1,
    OC_MALFORMED = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_AFTER_KEY,
    PH_AFTER_COLON,
    PH_STRING,
    PH_ESCAPE,
    PH_HEX,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  value_byte;
    logic [1:0]  outcome;
    logic [15:0] decoded_length;
    logic        final_mark;
  } result_t;

  typedef struct packed {
    logic [5:0]             key_length;
    logic [15:0]            out_capacity;
    logic [MaxKey-1:0][7:0] key_bytes;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/jkse_cfg_regs.sv
// APB configuration registers: key length, output capacity, key bytes.
// Depends on jkse_pkg.
`default_nettype none

module jkse_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [jkse_pkg::AddrW-1:0]  paddr,
  input  wire logic [jkse_pkg::DataW-1:0]  pwdata,
  output logic      [jkse_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  output jkse_pkg::cfg_t                   cfg_o
);
  import jkse_pkg::*;

  logic [5:0]                     key_len_q;
  logic [15:0]                    cap_q;
  logic [KeyWords-1:0][DataW-1:0] key_q;
  reg_idx_e                       idx;
  logic                           wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= 6'd0;
      cap_q     <= CapacityReset;
      key_q     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_KEY_LENGTH:   key_len_q <= pwdata[5:0];
        REG_OUT_CAPACITY: cap_q     <= pwdata[15:0];
        REG_KEY_A:        key_q[0]  <= pwdata;
        REG_KEY_B:        key_q[1]  <= pwdata;
        REG_KEY_C:        key_q[2]  <= pwdata;
        REG_KEY_D:        key_q[3]  <= pwdata;
        REG_KEY_E:        key_q[4]  <= pwdata;
        REG_KEY_F:        key_q[5]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY_LENGTH:   prdata = DataW'(key_len_q);
      REG_OUT_CAPACITY: prdata = DataW'(cap_q);
      REG_KEY_A:        prdata = key_q[0];
      REG_KEY_B:        prdata = key_q[1];
      REG_KEY_C:        prdata = key_q[2];
      REG_KEY_D:        prdata = key_q[3];
      REG_KEY_E:        prdata = key_q[4];
      REG_KEY_F:        prdata = key_q[5];
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.key_length   = key_len_q;
  assign cfg_o.out_capacity = cap_q;
  assign cfg_o.key_bytes    = key_q;

endmodule

`default_nettype wire

>>> rtl/core/json_keyed_string_extractor.sv
// A byte is registered in the input stage, then its result beat in the output register.
// Throughput: one text byte per cycle; a result beat held by out_ready_i blocks the
// input stage, so intake stops once that stage is full until the result is taken.
// Key search is a per-prefix match vector updated in the same pass as decode.
// Reset (rst_ni low, async): search phase, empty pipeline, config defaults.
// Depends on jkse_pkg and jkse_cfg_regs.
`default_nettype none

module json_keyed_string_extractor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire jkse_pkg::text_in_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output jkse_pkg::result_t                out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [jkse_pkg::AddrW-1:0]  paddr,
  input  wire logic [jkse_pkg::DataW-1:0]  pwdata,
  output logic      [jkse_pkg::DataW-1:0]  prdata,
  output logic                             pready
);
  import jkse_pkg::*;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowU   = 8'h75;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

  cfg_t cfg;

  jkse_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input stage
  logic     s1_valid_q;
  text_in_t s1_data_q;
  logic     advance;

  // state
  phase_e          phase_q, phase_d;
  logic [MaxKey:0] vec_q, vec_d, vec_sh;
  logic [15:0]     cnt_q, cnt_d;
  logic [1:0]      hex_idx_q, hex_idx_d;
  logic [3:0]      hex_low_q, hex_low_d;

  // decisions
  logic       dlv, emit_byte, fin;
  logic [7:0] dlv_ch;
  outcome_e   fin_oc;
  logic [5:0] eff_len;
  logic       key_hit;
  logic [4:0] h;
  logic [7:0] b;
  logic       last;

  logic    out_valid_q;
  result_t out_data_q, res;

  assign b    = s1_data_q.text_byte;
  assign last = s1_data_q.end_of_text;

  assign advance    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // key ends at its first zero byte
  always_comb begin
    eff_len = (cfg.key_length > 6'(MaxKey)) ? 6'(MaxKey) : cfg.key_length;
    for (int j = MaxKey - 1; j >= 0; j--) begin
      if (cfg.key_bytes[j] == 8'd0 && 6'(j) < cfg.key_length) eff_len = 6'(j);
    end
  end

  // vec_q[j]: the last j+1 search bytes are the opening quote and key[0..j-1]
  always_comb begin
    vec_sh[0] = (b == ChQuote);
    for (int j = 1; j <= MaxKey; j++) begin
      vec_sh[j] = vec_q[j-1] & (b == cfg.key_bytes[j-1]);
    end
  end

  assign key_hit = vec_q[eff_len] & (b == ChQuote);
  assign h       = hex_of(b);

  // next state
  always_comb begin
    phase_d   = phase_q;
    vec_d     = vec_q;
    cnt_d     = cnt_q;
    hex_idx_d = hex_idx_q;
    hex_low_d = hex_low_q;
    dlv       = 1'b0;
    dlv_ch    = 8'd0;
    emit_byte = 1'b0;
    fin       = 1'b0;
    fin_oc    = OC_NOT_FOUND;

    if (phase_q != PH_DONE && b != 8'd0) begin
      unique case (phase_q)
        PH_SEARCH: begin
          vec_d = vec_sh;
          if (key_hit) phase_d = PH_AFTER_KEY;
        end
        PH_AFTER_KEY: begin
          if (b == ChColon) begin
            phase_d = PH_AFTER_COLON;
          end else if (!is_ws(b)) begin
            phase_d  = PH_SEARCH;
            vec_d    = '0;
            vec_d[0] = (b == ChQuote);
          end
        end
        PH_AFTER_COLON: begin
          if (b == ChQuote) begin
            phase_d = PH_STRING;
          end else if (!is_ws(b)) begin
            fin    = 1'b1;
            fin_oc = OC_MALFORMED;
          end
        end
        PH_STRING: begin
          if (b < ChSpace) begin
            fin    = 1'b1;
            fin_oc = OC_MALFORMED;
          end else if (b == ChBslash) begin
            phase_d = PH_ESCAPE;
          end else if (b == ChQuote) begin
            fin    = 1'b1;
            fin_oc = OC_OK;
          end else begin
            dlv    = 1'b1;
            dlv_ch = b;
          end
        end
        PH_ESCAPE: begin
          case (b) inside
            ChQuote, ChBslash, ChSlash: begin
              dlv    = 1'b1;
              dlv_ch = b;
            end
            ChLowB: begin dlv = 1'b1; dlv_ch = 8'h08; end
            ChLowF: begin dlv = 1'b1; dlv_ch = 8'h0C; end
            ChLowN: begin dlv = 1'b1; dlv_ch = 8'h0A; end
            ChLowR: begin dlv = 1'b1; dlv_ch = 8'h0D; end
            ChLowT: begin dlv = 1'b1; dlv_ch = 8'h09; end
            ChLowU: begin
              phase_d   = PH_HEX;
              hex_idx_d = 2'd0;
              hex_low_d = 4'd0;
            end
            default: begin
              fin    = 1'b1;
              fin_oc = OC_MALFORMED;
            end
          endcase
        end
        PH_HEX: begin
          if (!hex_idx_q[1]) begin
            if (h != 5'd0) begin
              fin    = 1'b1;
              fin_oc = OC_MALFORMED;
            end else begin
              hex_idx_d = hex_idx_q + 2'd1;
            end
          end else if (h[4]) begin
            fin    = 1'b1;
            fin_oc = OC_MALFORMED;
          end else if (hex_idx_q == 2'd2) begin
            hex_low_d = h[3:0];
            hex_idx_d = 2'd3;
          end else begin
            hex_idx_d = 2'd0;
            dlv       = 1'b1;
            dlv_ch    = {hex_low_q, h[3:0]};
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end

    if (dlv) begin
      phase_d = PH_STRING;
      if ({1'b0, cnt_q} + 17'd1 >= {1'b0, cfg.out_capacity}) begin
        fin    = 1'b1;
        fin_oc = OC_MALFORMED;
      end else if (!last) begin
        cnt_d     = cnt_q + 16'd1;
        emit_byte = 1'b1;
      end
    end

    if (fin) phase_d = PH_DONE;

    if (phase_q != PH_DONE && phase_d != PH_DONE && (b == 8'd0 || last)) begin
      fin     = 1'b1;
      fin_oc  = (phase_d == PH_SEARCH || phase_d == PH_AFTER_KEY) ? OC_NOT_FOUND
                                                                   : OC_MALFORMED;
      phase_d = PH_DONE;
    end
  end

  // result beat
  always_comb begin
    res.result_kind    = fin ? KindFinal : KindByte;
    res.value_byte     = fin ? 8'd0 : dlv_ch;
    res.outcome        = fin ? fin_oc : OC_NOT_FOUND;
    res.decoded_length = cnt_d;
    res.final_mark     = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SEARCH;
      vec_q     <= '0;
      cnt_q     <= 16'd0;
      hex_idx_q <= 2'd0;
      hex_low_q <= 4'd0;
    end else if (advance) begin
      if (last) begin
        phase_q   <= PH_SEARCH;
        vec_q     <= '0;
        cnt_q     <= 16'd0;
        hex_idx_q <= 2'd0;
        hex_low_q <= 4'd0;
      end else begin
        phase_q   <= phase_d;
        vec_q     <= vec_d;
        cnt_q     <= cnt_d;
        hex_idx_q <= hex_idx_d;
        hex_low_q <= hex_low_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && (emit_byte || fin)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && (emit_byte || fin)) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && phase_q == PH_DONE |-> !(emit_byte || fin))
    else $error("result produced after final beat");

  a_cap_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit_byte |-> ({1'b0, cnt_d} < {1'b0, cfg.out_capacity}))
    else $error("decoded byte beyond capacity");

  a_text_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last |=> phase_q == PH_SEARCH && cnt_q == 16'd0 && vec_q == '0)
    else $error("state not cleared after end of text");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_data_q))
    else $error("input stage lost a pending beat");
`endif

endmodule

`default_nettype wire
